[rtl/slm_pkg.sv]
// ----------------------------------------------------------------------------
// slm_pkg
// shared types, register codes and constants of the rms sound level meter
// ----------------------------------------------------------------------------
package slm_pkg;

  typedef enum logic [1:0] {
    REG_MPC   = 2'd0,
    REG_CAL   = 2'd1,
    REG_DBREF = 2'd2,
    REG_ALPHA = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] mpc;
    logic [21:0] cal;
    logic [14:0] dbref;
    logic [15:0] alpha;
  } cfg_t;

  localparam logic [23:0] MPC_RESET   = 24'd206300;
  localparam logic [21:0] CAL_RESET   = 22'd10000;
  localparam logic [14:0] DBREF_RESET = 15'd24064;
  localparam logic [15:0] ALPHA_RESET = 16'd13107;

  // 20*log10(2) in q.24
  localparam logic [26:0] DB_LOG2_K = 27'd101008905;

  localparam int SAMPLE_W = 12;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/sound_level_rms_db_meter.sv]
// ----------------------------------------------------------------------------
// sound_level_rms_db_meter
// windowed rms level meter with db output and ema smoothing
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one adc sample per cycle while
// in_stall is low, together with last_in_window, which closes the current
// window after that sample. Every closed window yields one result item on
// the output channel (out_valid/out_stall): smoothed vrms in microvolts,
// db relative and db spl in q8.8, and ready_res (0 with all fields zero
// when the level is zero). Samples are accumulated at one per cycle while
// in_stall is low. A closed window goes into a two-entry queue; the math
// engine uses bit-serial multiplies, sqrt, divide, normalizing shifts of
// the level and of the calibration voltage and 2x16 log2 squarings.
// in_stall rises only while the queue holds two windows, so windows that
// take no less time to arrive than the engine takes per window stream with
// no stall. The result register holds an item while out_stall is high; the
// engine waits on it only at its end.
// Configuration writes (cfg_valid/cfg_ready, always ready) are applied next
// cycle. Reset clears accumulators, filter state and restores register
// defaults.
module sound_level_rms_db_meter #(
  parameter int ADC_BITS           = 12,
  parameter int MAX_WINDOW_SAMPLES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [11:0]         sample,
  input  logic                last_in_window,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [21:0]         vrms_microvolts,
  output logic signed [15:0]  db_relative_q8,
  output logic signed [15:0]  db_spl_q8,
  output logic                ready_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  slm_pkg::cfg_reg_t   cfg_index,
  input  logic [23:0]         cfg_data
);
  import slm_pkg::*;

  localparam int XW = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CW = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int SW = XW + CW;
  localparam int QW = 2 * XW + CW;
  localparam int JW = CW + SW + QW;

  cfg_t cfg;
  logic          q_full;
  logic          push;
  logic [CW-1:0] push_n;
  logic [SW-1:0] push_sum;
  logic [QW-1:0] push_sq;
  logic          pop;
  logic          q_valid;
  logic [JW-1:0] q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mpc   <= MPC_RESET;
      cfg.cal   <= CAL_RESET;
      cfg.dbref <= DBREF_RESET;
      cfg.alpha <= ALPHA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MPC:   cfg.mpc   <= cfg_data;
        REG_CAL:   cfg.cal   <= cfg_data[21:0];
        REG_DBREF: cfg.dbref <= cfg_data[14:0];
        REG_ALPHA: cfg.alpha <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  slm_front #(
    .XW   (XW),
    .CW   (CW),
    .MAXN (MAX_WINDOW_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .x        (sample[XW-1:0]),
    .last     (last_in_window),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_n   (push_n),
    .push_sum (push_sum),
    .push_sq  (push_sq)
  );

  slm_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sq, push_sum, push_n}),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  slm_back #(
    .XW (XW),
    .CW (CW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .vrms_microvolts (vrms_microvolts),
    .db_relative_q8  (db_relative_q8),
    .db_spl_q8       (db_spl_q8),
    .ready_res       (ready_res)
  );

endmodule

[rtl/slm_front.sv]
// ----------------------------------------------------------------------------
// slm_front
// window count, sum and sum of squares; if not stalled, one sample per cycle
// ----------------------------------------------------------------------------
module slm_front #(
  parameter int XW   = 12,
  parameter int CW   = 17,
  parameter int MAXN = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [XW-1:0]         x,
  input  logic                  last,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  push,
  output logic [CW-1:0]         push_n,
  output logic [XW+CW-1:0]      push_sum,
  output logic [2*XW+CW-1:0]    push_sq
);
  localparam int SW = XW + CW;
  localparam int QW = 2 * XW + CW;
  localparam logic [CW-1:0] MAX_N = CW'(MAXN);

  logic [CW-1:0] count;
  logic [SW-1:0] sum;
  logic [QW-1:0] sq;
  logic          accept;
  logic          room;
  logic [2*XW-1:0] x2;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign room     = count < MAX_N;
  assign x2       = x * x;

  // a full window ignores further samples
  assign push_n   = room ? count + CW'(1) : count;
  assign push_sum = room ? sum + SW'(x) : sum;
  assign push_sq  = room ? sq + QW'(x2) : sq;
  assign push     = accept && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      sq    <= '0;
    end else if (accept) begin
      if (last) begin
        count <= '0;
        sum   <= '0;
        sq    <= '0;
      end else begin
        count <= push_n;
        sum   <= push_sum;
        sq    <= push_sq;
      end
    end
  end

endmodule

[rtl/slm_queue.sv]
// ----------------------------------------------------------------------------
// slm_queue
// two-entry queue of closed windows between accumulators and math engine
// ----------------------------------------------------------------------------
module slm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] q_data
);
  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full    = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/slm_back.sv]
// ----------------------------------------------------------------------------
// slm_back
// window-end math: variance, sqrt, scaling, log2, db, ema and result register
// ----------------------------------------------------------------------------
module slm_back #(
  parameter int XW = 12,
  parameter int CW = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  slm_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  logic [3*XW+3*CW-1:0]  q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [21:0]           vrms_microvolts,
  output logic signed [15:0]    db_relative_q8,
  output logic signed [15:0]    db_spl_q8,
  output logic                  ready_res
);
  import slm_pkg::*;

  localparam int SW   = XW + CW;
  localparam int QW   = 2 * XW + CW;
  localparam int PW   = CW + QW;
  localparam int DW   = PW + 32;
  localparam int RW   = (DW + 1) / 2;
  localparam int SDW  = XW + 16;
  localparam int VW   = SDW + 24;
  localparam int EW   = $clog2(VW);
  localparam int LGW  = EW + 16;
  localparam int LW   = LGW + 2;
  localparam int PKW  = LW + 27;
  localparam int QQW  = PKW - 32;
  localparam int DBW  = LW - 2;
  localparam int CNTW = $clog2(RW + VW + SW + 64);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHK, S_SQRT, S_DIV, S_MULV, S_ZCHK,
    S_NORM, S_LOG, S_DBMUL, S_DB, S_EMA, S_OUT
  } state_t;

  state_t state;
  logic [CNTW-1:0]   cnt;
  logic [CW-1:0]     n_r;
  logic [SW-1:0]     sum_r;
  logic [QW-1:0]     sq_r;
  logic [SW-1:0]     nb;
  logic [SW-1:0]     sb;
  logic [PW-1:0]     p_acc;
  logic [PW-1:0]     s_acc;
  logic [2*RW-1:0]   dsh;
  logic [RW+1:0]     rem;
  logic [RW-1:0]     root;
  logic [RW-1:0]     quo;
  logic [CW-1:0]     dr;
  logic [23:0]       mb;
  logic [VW-1:0]     v_acc;
  logic [VW-1:0]     nrm;
  logic [EW-1:0]     ecnt;
  logic [31:0]       m;
  logic [15:0]       frac;
  logic              phase;
  logic [LGW-1:0]    lv;
  logic [LGW-1:0]    lc;
  logic [PKW-1:0]    prodk;
  logic              neg;
  logic              zres;
  logic [21:0]       x_vr;
  logic signed [15:0] x_dbr;
  logic signed [15:0] x_dbs;
  logic [21:0]       sm_vr;
  logic signed [15:0] sm_dbr;
  logic signed [15:0] sm_dbs;
  logic              primed;
  logic signed [42:0] acc;

  logic              res_valid;
  logic [21:0]       res_vr;
  logic signed [15:0] res_dbr;
  logic signed [15:0] res_dbs;
  logic              res_rdy;

  // datapath helpers
  logic [RW+3:0]     rem_t;
  logic [RW+3:0]     trial;
  logic              sq_ge;
  logic [CW:0]       dr_t;
  logic              dv_ge;
  logic [63:0]       mm;
  logic [32:0]       t;
  logic [15:0]       frac_next;
  logic signed [LW-1:0] lval;
  logic [LW-1:0]     mag;
  logic [PKW-1:0]    qsum;
  logic [QQW-1:0]    q;
  logic signed [DBW-1:0] dbr;
  logic signed [DBW-1:0] dbs;
  logic [16:0]       opa;
  logic signed [22:0] opb;
  logic signed [40:0] prod;
  logic signed [42:0] acc_next;
  logic signed [42:0] ema_res;
  logic              out_free;

  assign pop = (state == S_IDLE) && q_valid;

  assign rem_t = {rem, dsh[2*RW-1 -: 2]};
  assign trial = (RW+4)'({root, 2'b01});
  assign sq_ge = rem_t >= trial;

  assign dr_t  = {dr, quo[RW-1]};
  assign dv_ge = dr_t >= {1'b0, n_r};

  assign mm        = m * m;
  assign t         = mm[63:31];
  assign frac_next = {frac[14:0], t[32]};

  assign lval = $signed({2'b0, lv}) - $signed({2'b0, lc}) - $signed(LW'(24 << 16));
  assign mag  = lval[LW-1] ? LW'(-lval) : LW'(lval);

  // round to nearest on the 2^32 scale, ties away from zero via magnitude
  assign qsum = prodk + PKW'(33'h080000000);
  assign q    = qsum[PKW-1:32];
  assign dbr  = neg ? -$signed(DBW'(q)) : $signed(DBW'(q));
  assign dbs  = $signed(DBW'({1'b0, cfg.dbref})) + dbr;

  always_comb begin
    opa = cnt[0] ? 17'd65536 - 17'(cfg.alpha) : 17'(cfg.alpha);
    case (cnt[2:0])
      3'd0:    opb = $signed({1'b0, x_vr});
      3'd1:    opb = $signed({1'b0, sm_vr});
      3'd2:    opb = 23'(x_dbr);
      3'd3:    opb = 23'(sm_dbr);
      3'd4:    opb = 23'(x_dbs);
      default: opb = 23'(sm_dbs);
    endcase
  end

  assign prod     = $signed({1'b0, opa}) * opb;
  assign acc_next = (cnt[0] ? acc : 43'sd32768) + 43'(prod);
  assign ema_res  = acc_next >>> 16;
  assign out_free = !res_valid || !out_stall;

  assign out_valid       = res_valid;
  assign vrms_microvolts = res_vr;
  assign db_relative_q8  = res_dbr;
  assign db_spl_q8       = res_dbs;
  assign ready_res       = res_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      primed    <= 1'b0;
      sm_vr     <= '0;
      sm_dbr    <= '0;
      sm_dbs    <= '0;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // the output state reloads the result register itself
      if (res_valid && !out_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            n_r   <= q_data[CW-1:0];
            sum_r <= q_data[CW +: SW];
            sq_r  <= q_data[CW+SW +: QW];
            nb    <= SW'(q_data[CW-1:0]);
            sb    <= q_data[CW +: SW];
            p_acc <= '0;
            s_acc <= '0;
            cnt   <= CNTW'(SW);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_acc <= {p_acc[PW-2:0], 1'b0} + (nb[SW-1] ? PW'(sq_r) : '0);
          s_acc <= {s_acc[PW-2:0], 1'b0} + (sb[SW-1] ? PW'(sum_r) : '0);
          nb    <= nb << 1;
          sb    <= sb << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (p_acc > s_acc && n_r != '0) begin
            dsh   <= (2*RW)'({p_acc - s_acc, 32'b0});
            rem   <= '0;
            root  <= '0;
            cnt   <= CNTW'(RW);
            state <= S_SQRT;
          end else begin
            zres  <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SQRT: begin
          rem   <= sq_ge ? (RW+2)'(rem_t - trial) : (RW+2)'(rem_t);
          root  <= {root[RW-2:0], sq_ge};
          dsh   <= dsh << 2;
          if (cnt == CNTW'(1)) begin
            quo   <= {root[RW-2:0], sq_ge};
            dr    <= '0;
            cnt   <= CNTW'(RW);
            state <= S_DIV;
          end else begin
            cnt   <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          dr  <= dv_ge ? CW'(dr_t - {1'b0, n_r}) : CW'(dr_t);
          quo <= {quo[RW-2:0], dv_ge};
          if (cnt == CNTW'(1)) begin
            mb    <= cfg.mpc;
            v_acc <= '0;
            cnt   <= CNTW'(24);
            state <= S_MULV;
          end else begin
            cnt   <= cnt - 1'b1;
          end
        end
        S_MULV: begin
          v_acc <= {v_acc[VW-2:0], 1'b0} + (mb[23] ? VW'(quo[SDW-1:0]) : '0);
          mb    <= mb << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= S_ZCHK;
          end
        end
        S_ZCHK: begin
          if (v_acc == '0) begin
            zres  <= 1'b1;
            state <= S_OUT;
          end else begin
            zres  <= 1'b0;
            x_vr  <= (v_acc[VW-1:46] != '0) ? 22'h3fffff : v_acc[45:24];
            nrm   <= v_acc;
            ecnt  <= EW'(VW - 1);
            phase <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // one bit of normalizing shift per cycle
          if (nrm[VW-1]) begin
            m     <= nrm[VW-1 -: 32];
            frac  <= '0;
            cnt   <= CNTW'(16);
            state <= S_LOG;
          end else begin
            nrm  <= nrm << 1;
            ecnt <= ecnt - 1'b1;
          end
        end
        S_LOG: begin
          m    <= t[32] ? t[32:1] : t[31:0];
          frac <= frac_next;
          cnt  <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            if (!phase) begin
              lv    <= {ecnt, frac_next};
              nrm   <= (cfg.cal == '0) ? VW'(1) : VW'(cfg.cal);
              ecnt  <= EW'(VW - 1);
              phase <= 1'b1;
              state <= S_NORM;
            end else begin
              lc    <= {ecnt, frac_next};
              state <= S_DBMUL;
            end
          end
        end
        S_DBMUL: begin
          prodk <= PKW'(mag) * PKW'(DB_LOG2_K);
          neg   <= lval[LW-1];
          state <= S_DB;
        end
        S_DB: begin
          if (!primed) begin
            sm_vr  <= x_vr;
            sm_dbr <= sat16(32'(dbr));
            sm_dbs <= sat16(32'(dbs));
            primed <= 1'b1;
            state  <= S_OUT;
          end else begin
            x_dbr <= sat16(32'(dbr));
            x_dbs <= sat16(32'(dbs));
            cnt   <= '0;
            state <= S_EMA;
          end
        end
        S_EMA: begin
          acc <= acc_next;
          cnt <= cnt + 1'b1;
          case (cnt[2:0])
            3'd1:    sm_vr  <= ema_res[21:0];
            3'd3:    sm_dbr <= ema_res[15:0];
            3'd5:    sm_dbs <= ema_res[15:0];
            default: ;
          endcase
          if (cnt == CNTW'(5)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_rdy   <= !zres;
            res_vr    <= zres ? '0 : sm_vr;
            res_dbr   <= zres ? '0 : sm_dbr;
            res_dbs   <= zres ? '0 : sm_dbs;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_zero_result : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_rdy |-> res_vr == '0 && res_dbr == '0 && res_dbs == '0)
    else $error("zero-level result carries nonzero fields");

  a_primed : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_rdy |-> primed)
    else $error("valid level delivered with filter not primed");

  a_pop : assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_MUL)
    else $error("window taken from queue without starting math");

  a_reset : assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !primed)
    else $error("result or filter state survived reset");
`endif

endmodule
